### hdl/ultrasonic_echo_ranger_macros.svh
// assertion macros for the ultrasonic echo ranger
// no dependencies; included by the top level
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// same-cycle implication, disabled during reset
`define UER_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uer assertion failed");

// next-cycle implication, disabled during reset
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uer assertion failed");

`endif

### hdl/uer_pkg.sv
// shared types, constants and the distance function of the echo ranger
// no dependencies
`timescale 1ns / 1ps

package uer_pkg;

    // time of day value
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    // time of day loaded at reset
    localparam logic [4:0] RST_HOUR   = 5'd21;
    localparam logic [5:0] RST_MINUTE = 6'd30;
    localparam logic [5:0] RST_SECOND = 6'd0;

    // wrap limits of the clock
    localparam logic [5:0] SEC_PER_MIN  = 6'd60;
    localparam logic [5:0] MIN_PER_HOUR = 6'd60;
    localparam logic [4:0] HOUR_PER_DAY = 5'd24;

    // register indexes
    localparam logic [2:0] CFG_TRIGGER_LEN   = 3'd0;
    localparam logic [2:0] CFG_ECHO_TIMEOUT  = 3'd1;
    localparam logic [2:0] CFG_LISTEN_WINDOW = 3'd2;
    localparam logic [2:0] CFG_MEASURE_PER   = 3'd3;
    localparam logic [2:0] CFG_SECOND_LEN    = 3'd4;
    localparam logic [2:0] CFG_START_HOUR    = 3'd5;
    localparam logic [2:0] CFG_START_MINUTE  = 3'd6;
    localparam logic [2:0] CFG_START_SECOND  = 3'd7;

    // register reset values
    localparam logic [7:0]  RST_TRIGGER_LEN   = 8'd10;
    localparam logic [15:0] RST_ECHO_TIMEOUT  = 16'd30000;
    localparam logic [15:0] RST_LISTEN_WINDOW = 16'd50000;
    localparam logic [19:0] RST_MEASURE_PER   = 20'd1000000;
    localparam logic [19:0] RST_SECOND_LEN    = 20'd1000000;

    // cm per us round trip as 0.0343 / 2 in q16
    localparam logic [10:0] CM_PER_US_Q16 = 11'd1124;
    localparam logic [26:0] Q16_HALF      = 27'd32768;

    function automatic logic [10:0] f_distance_cm(input logic [15:0] width_us);
        logic [26:0] prod;
        begin
            prod = 27'(width_us) * 27'(CM_PER_US_Q16) + Q16_HALF;
            f_distance_cm = prod[26:16];
        end
    endfunction

endpackage

### hdl/uer_tod.sv
// time of day counter: hours, minutes, seconds from a tick count
// depends on uer_pkg
`timescale 1ns / 1ps

module uer_tod (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tick,
    input  logic [19:0]    i_second_len,
    output uer_pkg::t_tod  o_next
);
    import uer_pkg::*;

    logic [19:0] r_second_count, n_second_count;
    t_tod        r_tod, n_tod;
    logic [19:0] sc_inc;
    logic [5:0]  sec_inc, min_inc;
    logic [4:0]  hour_inc;

    always_comb begin
        sc_inc   = r_second_count + 20'd1;
        sec_inc  = r_tod.second + 6'd1;
        min_inc  = r_tod.minute + 6'd1;
        hour_inc = r_tod.hour + 5'd1;
        n_tod    = r_tod;
        if (sc_inc < i_second_len && sc_inc != 20'd0) begin
            n_second_count = sc_inc;
        end else begin
            n_second_count = '0;
            n_tod.second   = sec_inc;
            if (sec_inc >= SEC_PER_MIN) begin
                n_tod.second = '0;
                n_tod.minute = min_inc;
                if (min_inc >= MIN_PER_HOUR) begin
                    n_tod.minute = '0;
                    n_tod.hour   = (hour_inc >= HOUR_PER_DAY) ? 5'd0 : hour_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_count <= '0;
            r_tod          <= '{hour: RST_HOUR, minute: RST_MINUTE, second: RST_SECOND};
        end else if (i_tick) begin
            r_second_count <= n_second_count;
            r_tod          <= n_tod;
        end
    end

    assign o_next = n_tod;

endmodule

### hdl/ultrasonic_echo_ranger.sv
// ultrasonic echo ranger: one input beat per microsecond tick, one result beat per tick
// latency: a result beat is valid in the cycle after its input beat is accepted
// throughput: one beat per cycle; o_ready drops only while a result waits unaccepted
// reset (synchronous, active low): registers to defaults, measuring stopped,
// clock at 21:30:00, output register empty
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
    parameter int ECHO_COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    // input tick channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_echo_level,
    input  logic [1:0]  i_func,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_trigger_level,
    output logic        o_report_valid,
    output logic        o_report_fail,
    output logic [10:0] o_distance_cm,
    output logic [15:0] o_echo_width_us,
    output logic [4:0]  o_clock_hour,
    output logic [5:0]  o_clock_minute,
    output logic [5:0]  o_clock_second,
    output logic        o_is_active
);
    import uer_pkg::*;

    `include "ultrasonic_echo_ranger_macros.svh"

    localparam int CB = ECHO_COUNT_BITS;
    // wide enough for both the echo counter and the 16 bit fields
    localparam int WB = (CB > 16) ? CB : 16;
    localparam logic [CB-1:0] ECHO_MAX = {CB{1'b1}};

    // measurement phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_TRIG   = 2'd1;
    localparam logic [1:0] PH_LISTEN = 2'd2;

    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    localparam logic [19:0] PERIOD_MAX = 20'hFFFFF;

    // configuration registers
    logic [7:0]  r_trig_len;
    logic [15:0] r_echo_timeout;
    logic [15:0] r_listen_window;
    logic [19:0] r_measure_period;
    logic [19:0] r_second_len;

    // measurement state
    logic          r_active, n_active;
    logic [19:0]   r_period_count, n_period_count;
    logic [1:0]    r_phase, n_phase;
    logic [15:0]   r_phase_count, n_phase_count;
    logic          r_echo_prev;
    logic [CB-1:0] r_echo_count, n_echo_count;
    logic [15:0]   r_echo_width, n_echo_width;
    logic          r_received, n_received;
    logic          r_timed_out, n_timed_out;
    logic          r_armed, n_armed;

    // result register
    logic        r_out_valid;
    logic        r_trig, n_trig;
    logic        r_rep_valid, n_rep_valid;
    logic        r_rep_fail, n_rep_fail;
    logic [10:0] r_dist, n_dist;
    logic [15:0] r_width, n_width;
    t_tod        r_tod;
    t_tod        tod_next;

    logic          in_accept;
    logic [WB-1:0] ec_wide;
    logic [15:0]   phc_inc;

    // input is taken whenever the result register is free or being drained
    assign o_ready     = !r_out_valid || i_ready;
    assign in_accept   = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // configuration writes; start time registers only matter at reset,
    // where they hold their defaults, so a write to them has no effect
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_len       <= RST_TRIGGER_LEN;
            r_echo_timeout   <= RST_ECHO_TIMEOUT;
            r_listen_window  <= RST_LISTEN_WINDOW;
            r_measure_period <= RST_MEASURE_PER;
            r_second_len     <= RST_SECOND_LEN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TRIGGER_LEN:   r_trig_len       <= i_cfg_data[7:0];
                CFG_ECHO_TIMEOUT:  r_echo_timeout   <= i_cfg_data[15:0];
                CFG_LISTEN_WINDOW: r_listen_window  <= i_cfg_data[15:0];
                CFG_MEASURE_PER:   r_measure_period <= i_cfg_data;
                CFG_SECOND_LEN:    r_second_len     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // time of day advances once per accepted tick
    uer_tod u_tod (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (in_accept),
        .i_second_len (r_second_len),
        .o_next       (tod_next)
    );

    // one tick of the measurement sequencer
    always_comb begin
        n_active       = r_active;
        n_period_count = r_period_count;
        n_phase        = r_phase;
        n_phase_count  = r_phase_count;
        n_echo_count   = r_echo_count;
        n_echo_width   = r_echo_width;
        n_received     = r_received;
        n_timed_out    = r_timed_out;
        n_armed        = r_armed;
        n_trig         = 1'b0;
        n_rep_valid    = 1'b0;
        n_rep_fail     = 1'b0;
        n_dist         = '0;
        n_width        = '0;

        // start / stop command
        if (i_func == FUNC_START) begin
            n_active = 1'b1;
        end else if (i_func == FUNC_STOP) begin
            n_active = 1'b0;
        end

        // idle: launch a trigger once the period has elapsed
        if (r_phase == PH_IDLE) begin
            if (n_active && r_period_count >= r_measure_period) begin
                n_phase       = PH_TRIG;
                n_phase_count = '0;
                n_received    = 1'b0;
                n_timed_out   = 1'b0;
            end else if (r_period_count != PERIOD_MAX) begin
                n_period_count = r_period_count + 20'd1;
            end
        end

        // echo edges, watched on every tick
        if (i_echo_level && !r_echo_prev) begin
            n_echo_count = CB'(1);
            n_received   = 1'b0;
            n_armed      = 1'b1;
        end else if (i_echo_level) begin
            if (r_echo_count != ECHO_MAX) begin
                n_echo_count = r_echo_count + CB'(1);
            end
        end else if (r_echo_prev) begin
            n_echo_width = (WB'(r_echo_count) > WB'(16'hFFFF))
                         ? 16'hFFFF : 16'(r_echo_count);
            n_received   = 1'b1;
            n_timed_out  = 1'b0;
            n_armed      = 1'b0;
        end

        // timeout on a long echo
        ec_wide = WB'(n_echo_count);
        if (n_armed && ec_wide >= WB'(r_echo_timeout)) begin
            n_timed_out = 1'b1;
            n_received  = 1'b0;
            n_armed     = 1'b0;
        end

        // trigger pulse and listen window
        phc_inc = n_phase_count + 16'd1;
        case (n_phase)
            PH_IDLE: begin
            end
            PH_TRIG: begin
                n_trig        = 1'b1;
                n_phase_count = phc_inc;
                if (phc_inc >= 16'(r_trig_len)) begin
                    n_phase       = PH_LISTEN;
                    n_phase_count = '0;
                end
            end
            PH_LISTEN: begin
                n_phase_count = phc_inc;
                // window end, also on counter wrap
                if (phc_inc >= r_listen_window || phc_inc == 16'd0) begin
                    if (n_received) begin
                        n_rep_valid = 1'b1;
                        n_width     = n_echo_width;
                        n_dist      = f_distance_cm(n_echo_width);
                    end else if (n_timed_out) begin
                        n_rep_valid = 1'b1;
                        n_rep_fail  = 1'b1;
                    end
                    n_phase        = PH_IDLE;
                    n_phase_count  = '0;
                    n_period_count = '0;
                end
            end
            default: begin
                n_phase       = PH_IDLE;
                n_phase_count = '0;
            end
        endcase
    end

    // state update on accepted ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_period_count <= '0;
            r_phase        <= PH_IDLE;
            r_phase_count  <= '0;
            r_echo_prev    <= 1'b0;
            r_echo_count   <= '0;
            r_echo_width   <= '0;
            r_received     <= 1'b0;
            r_timed_out    <= 1'b0;
            r_armed        <= 1'b0;
        end else if (in_accept) begin
            r_active       <= n_active;
            r_period_count <= n_period_count;
            r_phase        <= n_phase;
            r_phase_count  <= n_phase_count;
            r_echo_prev    <= i_echo_level;
            r_echo_count   <= n_echo_count;
            r_echo_width   <= n_echo_width;
            r_received     <= n_received;
            r_timed_out    <= n_timed_out;
            r_armed        <= n_armed;
        end
    end

    // result register: valid bit reset, payload loaded with each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_trig      <= n_trig;
            r_rep_valid <= n_rep_valid;
            r_rep_fail  <= n_rep_fail;
            r_dist      <= n_dist;
            r_width     <= n_width;
            r_tod       <= tod_next;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_trigger_level = r_trig;
    assign o_report_valid  = r_rep_valid;
    assign o_report_fail   = r_rep_fail;
    assign o_distance_cm   = r_dist;
    assign o_echo_width_us = r_width;
    assign o_clock_hour    = r_tod.hour;
    assign o_clock_minute  = r_tod.minute;
    assign o_clock_second  = r_tod.second;
    // active flag as it stands after this tick's command
    logic r_out_active;
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_active <= n_active;
        end
    end
    assign o_is_active = r_out_active;

    // every accepted tick leaves a result behind
    `UER_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, in_accept, r_out_valid)
    // a timeout and a received echo never stand together
    `UER_ASSERT_IMPL(a_rx_to_excl, i_clk, i_rst_n, 1'b1, !(r_received && r_timed_out))
    // reports come only in the listen window, never with the trigger high
    `UER_ASSERT_IMPL(a_trig_no_rep, i_clk, i_rst_n, r_out_valid && r_trig, !r_rep_valid)
    // a failure carries no width and no distance
    `UER_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, r_out_valid && r_rep_fail,
        r_rep_valid && r_dist == 11'd0 && r_width == 16'd0)

endmodule

### tb/uer_tb_pkg.sv
// command codes of the input tick channel, shared by the stimulus and the checker
// no dependencies
`timescale 1ns / 1ps

package uer_tb_pkg;

    typedef enum logic [1:0] {
        FUNC_NONE  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_SPARE = 2'd3
    } func_e;

endpackage

### tb/uer_checker.sv
// checker of the ultrasonic echo ranger: follows the config, tick and result channels,
// predicts each result beat from the accepted tick beats and compares them
// depends on uer_pkg and uer_tb_pkg
`timescale 1ns / 1ps

module uer_checker
    import uer_pkg::*;
    import uer_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_tick_valid,
    input  logic        i_tick_ready,
    input  logic        i_echo_level,
    input  logic [1:0]  i_func,
    input  logic        i_rep_valid,
    input  logic        i_rep_ready,
    input  logic        i_trigger_level,
    input  logic        i_report_valid,
    input  logic        i_report_fail,
    input  logic [10:0] i_distance_cm,
    input  logic [15:0] i_echo_width_us,
    input  logic [4:0]  i_clock_hour,
    input  logic [5:0]  i_clock_minute,
    input  logic [5:0]  i_clock_second,
    input  logic        i_is_active,
    output int          o_pending,
    output int          o_errors
);

    localparam int          PULSE_BITS = 16;
    localparam logic [31:0] DIST_SCALE = 32'd1124;
    localparam logic [31:0] DIST_ROUND = 32'd32768;

    typedef enum logic [1:0] {SENSE_IDLE, SENSE_TRIG, SENSE_LISTEN} sense_phase_e;

    typedef struct packed {
        logic        trigger;
        logic        report;
        logic        fail;
        logic [10:0] dist_cm;
        logic [15:0] width;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        active;
    } tick_out_t;

    // register copies
    logic [7:0]  trig_len;
    logic [15:0] echo_tmo;
    logic [15:0] win_len;
    logic [19:0] per_len;
    logic [19:0] sec_len;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [5:0]  start_second;

    // ranger state
    logic                  running;
    logic [19:0]           idle_ticks;
    sense_phase_e          phase;
    logic [15:0]           phase_ticks;
    logic                  echo_last;
    logic [PULSE_BITS-1:0] pulse_ticks;
    logic [15:0]           pulse_width;
    logic                  got_echo;
    logic                  timed_out;
    logic                  tmo_armed;
    logic [4:0]            tod_hour;
    logic [5:0]            tod_min;
    logic [5:0]            tod_sec;
    logic [19:0]           tod_ticks;

    tick_out_t tick_reports[$];
    int        error_count = 0;

    task automatic reset_ranger();
        trig_len     = RST_TRIGGER_LEN;
        echo_tmo     = RST_ECHO_TIMEOUT;
        win_len      = RST_LISTEN_WINDOW;
        per_len      = RST_MEASURE_PER;
        sec_len      = RST_SECOND_LEN;
        start_hour   = RST_HOUR;
        start_minute = RST_MINUTE;
        start_second = RST_SECOND;
        running      = 1'b0;
        idle_ticks   = '0;
        phase        = SENSE_IDLE;
        phase_ticks  = '0;
        echo_last    = 1'b0;
        pulse_ticks  = '0;
        pulse_width  = '0;
        got_echo     = 1'b0;
        timed_out    = 1'b0;
        tmo_armed    = 1'b0;
        tod_hour     = start_hour;
        tod_min      = start_minute;
        tod_sec      = start_second;
        tod_ticks    = '0;
    endtask

    task automatic write_register(input logic [2:0] index, input logic [19:0] data);
        case (index)
            CFG_TRIGGER_LEN:   trig_len     = data[7:0];
            CFG_ECHO_TIMEOUT:  echo_tmo     = data[15:0];
            CFG_LISTEN_WINDOW: win_len      = data[15:0];
            CFG_MEASURE_PER:   per_len      = data;
            CFG_SECOND_LEN:    sec_len      = data;
            CFG_START_HOUR:    start_hour   = data[4:0];
            CFG_START_MINUTE:  start_minute = data[5:0];
            CFG_START_SECOND:  start_second = data[5:0];
            default: ;
        endcase
    endtask

    // one microsecond tick of the ranger
    task automatic predict_tick(input logic echo, input func_e func, output tick_out_t res);
        logic [31:0] prod;
        res = '0;

        tod_ticks = tod_ticks + 20'd1;
        if (tod_ticks >= sec_len || tod_ticks == 20'd0) begin
            tod_ticks = '0;
            tod_sec   = tod_sec + 6'd1;
            if (tod_sec >= SEC_PER_MIN) begin
                tod_sec = '0;
                tod_min = tod_min + 6'd1;
                if (tod_min >= MIN_PER_HOUR) begin
                    tod_min  = '0;
                    tod_hour = tod_hour + 5'd1;
                    if (tod_hour >= HOUR_PER_DAY) tod_hour = '0;
                end
            end
        end

        if (func == FUNC_START) running = 1'b1;
        else if (func == FUNC_STOP) running = 1'b0;

        if (phase == SENSE_IDLE) begin
            if (running && idle_ticks >= per_len) begin
                phase       = SENSE_TRIG;
                phase_ticks = '0;
                got_echo    = 1'b0;
                timed_out   = 1'b0;
            end else if (idle_ticks != 20'hFFFFF) begin
                idle_ticks = idle_ticks + 20'd1;
            end
        end

        if (echo && !echo_last) begin
            pulse_ticks = PULSE_BITS'(1);
            got_echo    = 1'b0;
            tmo_armed   = 1'b1;
        end else if (echo) begin
            if (pulse_ticks != '1) pulse_ticks = pulse_ticks + 1'b1;
        end else if (echo_last) begin
            pulse_width = pulse_ticks;
            got_echo    = 1'b1;
            timed_out   = 1'b0;
            tmo_armed   = 1'b0;
        end
        if (tmo_armed && pulse_ticks >= echo_tmo) begin
            timed_out = 1'b1;
            got_echo  = 1'b0;
            tmo_armed = 1'b0;
        end
        echo_last = echo;

        case (phase)
            SENSE_TRIG: begin
                res.trigger = 1'b1;
                phase_ticks = phase_ticks + 16'd1;
                if (phase_ticks >= {8'd0, trig_len}) begin
                    phase       = SENSE_LISTEN;
                    phase_ticks = '0;
                end
            end
            SENSE_LISTEN: begin
                phase_ticks = phase_ticks + 16'd1;
                if (phase_ticks >= win_len || phase_ticks == 16'd0) begin
                    if (got_echo) begin
                        res.report  = 1'b1;
                        res.width   = pulse_width;
                        prod        = {16'd0, pulse_width} * DIST_SCALE + DIST_ROUND;
                        res.dist_cm = prod[26:16];
                    end else if (timed_out) begin
                        res.report = 1'b1;
                        res.fail   = 1'b1;
                    end
                    phase       = SENSE_IDLE;
                    phase_ticks = '0;
                    idle_ticks  = '0;
                end
            end
            default: ;
        endcase

        res.hour   = tod_hour;
        res.minute = tod_min;
        res.second = tod_sec;
        res.active = running;
    endtask

    function automatic string show(input tick_out_t r);
        return $sformatf("trig %0d rep %0d fail %0d dist %0d width %0d tod %0d:%0d:%0d act %0d",
                         r.trigger, r.report, r.fail, r.dist_cm, r.width,
                         r.hour, r.minute, r.second, r.active);
    endfunction

    always @(posedge i_clk) begin : watch
        tick_out_t got;
        tick_out_t want;
        if (!i_rst_n) begin
            reset_ranger();
            tick_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_rep_valid && i_rep_ready) begin
                got = '{i_trigger_level, i_report_valid, i_report_fail, i_distance_cm,
                        i_echo_width_us, i_clock_hour, i_clock_minute, i_clock_second,
                        i_is_active};
                if (tick_reports.size() == 0) begin
                    if (error_count < 10)
                        $display("%0t: result beat with no tick waiting: %s", $realtime, show(got));
                    error_count++;
                end else begin
                    want = tick_reports.pop_front();
                    if (got !== want) begin
                        if (error_count < 10)
                            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, show(want), show(got));
                        error_count++;
                    end
                end
            end
            if (i_tick_valid && i_tick_ready) begin
                predict_tick(i_echo_level, func_e'(i_func), want);
                tick_reports.push_back(want);
            end
        end
        o_pending <= tick_reports.size();
        o_errors  <= error_count;
    end

endmodule

### tb/testbench.sv
// top of the ultrasonic echo ranger testbench: clock, reset, config writes, tick
// stimulus with random idling on both sides, and the final verdict
// depends on uer_pkg, uer_tb_pkg, uer_checker and the ranger itself
`timescale 1ns / 1ps

module testbench;
    import uer_pkg::*;
    import uer_tb_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    logic        i_echo_level = 1'b0;
    logic [1:0]  i_func      = FUNC_NONE;
    logic        i_ready     = 1'b0;

    logic        o_cfg_ready;
    logic        o_ready;
    logic        o_valid;
    logic        o_trigger_level;
    logic        o_report_valid;
    logic        o_report_fail;
    logic [10:0] o_distance_cm;
    logic [15:0] o_echo_width_us;
    logic [4:0]  o_clock_hour;
    logic [5:0]  o_clock_minute;
    logic [5:0]  o_clock_second;
    logic        o_is_active;

    int pending;
    int errors;

    // idle percentages of the tick sender and the result receiver
    int src_pct = 0;
    int snk_pct = 0;

    // state of the echo pulse generator, kept across phases
    logic echo_now = 1'b0;
    int   echo_run = 0;

    ultrasonic_echo_ranger uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_echo_level    (i_echo_level),
        .i_func          (i_func),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_trigger_level (o_trigger_level),
        .o_report_valid  (o_report_valid),
        .o_report_fail   (o_report_fail),
        .o_distance_cm   (o_distance_cm),
        .o_echo_width_us (o_echo_width_us),
        .o_clock_hour    (o_clock_hour),
        .o_clock_minute  (o_clock_minute),
        .o_clock_second  (o_clock_second),
        .o_is_active     (o_is_active)
    );

    uer_checker ranger_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_tick_valid    (i_valid),
        .i_tick_ready    (o_ready),
        .i_echo_level    (i_echo_level),
        .i_func          (i_func),
        .i_rep_valid     (o_valid),
        .i_rep_ready     (i_ready),
        .i_trigger_level (o_trigger_level),
        .i_report_valid  (o_report_valid),
        .i_report_fail   (o_report_fail),
        .i_distance_cm   (o_distance_cm),
        .i_echo_width_us (o_echo_width_us),
        .i_clock_hour    (o_clock_hour),
        .i_clock_minute  (o_clock_minute),
        .i_clock_second  (o_clock_second),
        .i_is_active     (o_is_active),
        .o_pending       (pending),
        .o_errors        (errors)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result receiver, stalls at random when snk_pct is nonzero
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= snk_pct);
    end

    // one tick beat; valid stays high across back to back beats
    task automatic drive_tick(input logic echo, input func_e func);
        while ($urandom_range(99) < src_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_echo_level <= echo;
        i_func       <= func;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // one config beat; the caller drops valid with cfg_close after the last one
    task automatic cfg_write(input logic [2:0] index, input logic [19:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic cfg_close();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic cfg_timing(input logic [19:0] trig, input logic [19:0] tmo,
                              input logic [19:0] win, input logic [19:0] per,
                              input logic [19:0] sec);
        cfg_write(CFG_TRIGGER_LEN, trig);
        cfg_write(CFG_ECHO_TIMEOUT, tmo);
        cfg_write(CFG_LISTEN_WINDOW, win);
        cfg_write(CFG_MEASURE_PER, per);
        cfg_write(CFG_SECOND_LEN, sec);
    endtask

    // entered at the step of the last accepted tick beat; returns after every
    // result has been taken
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // mostly well formed echo pulses with some noise on the pin and on the command
    task automatic run_random_phase(input int n_items);
        int    k;
        int    r;
        logic  echo_bit;
        func_e fn;
        for (k = 0; k < n_items; k++) begin
            if (echo_run == 0) begin
                echo_now = ~echo_now;
                echo_run = echo_now ? $urandom_range(40, 1) : $urandom_range(12, 1);
            end
            echo_run--;
            echo_bit = ($urandom_range(99) < 8) ? 1'($urandom_range(1)) : echo_now;
            r = $urandom_range(99);
            if (k == 0) fn = FUNC_START;
            else if (r < 85) fn = FUNC_NONE;
            else if (r < 90) fn = FUNC_START;
            else if (r < 94) fn = FUNC_STOP;
            else if (r < 97) fn = FUNC_SPARE;
            else fn = func_e'($urandom_range(3));
            // now and then hold off until the result side is empty
            if (k == 25 || $urandom_range(99) < 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            drive_tick(echo_bit, fn);
        end
        wait_drained();
    endtask

    initial begin : stimulus
        int p;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one full measurement: trigger right after start, a long echo that
        // falls before the window ends; the second length of zero makes the
        // clock step every tick, and start time writes only count at reset
        cfg_timing(20'd1, 20'hFFFFF, 20'd60, 20'd0, 20'd0);
        cfg_write(CFG_START_HOUR, 20'hFFFFF);
        cfg_write(CFG_START_MINUTE, 20'd59);
        cfg_write(CFG_START_SECOND, 20'd0);
        cfg_close();
        drive_tick(1'b1, FUNC_START);
        repeat (48) drive_tick(1'b1, FUNC_NONE);
        repeat (15) drive_tick(1'b0, FUNC_NONE);
        drive_tick(1'b0, FUNC_STOP);
        wait_drained();

        // zero trigger and window lengths, short pulses, timeouts, spare command,
        // stop while a measurement runs
        cfg_timing(20'd0, 20'd2, 20'd0, 20'd0, 20'd1);
        cfg_close();
        drive_tick(1'b0, FUNC_START); drive_tick(1'b1, FUNC_NONE);
        drive_tick(1'b0, FUNC_NONE);  drive_tick(1'b0, FUNC_NONE);
        drive_tick(1'b1, FUNC_NONE);  drive_tick(1'b1, FUNC_NONE);
        drive_tick(1'b1, FUNC_NONE);  drive_tick(1'b1, FUNC_NONE);
        drive_tick(1'b1, FUNC_NONE);  drive_tick(1'b1, FUNC_STOP);
        drive_tick(1'b1, FUNC_NONE);  drive_tick(1'b0, FUNC_NONE);
        drive_tick(1'b0, FUNC_SPARE); drive_tick(1'b1, FUNC_START);
        drive_tick(1'b0, FUNC_NONE);  drive_tick(1'b0, FUNC_NONE);
        drive_tick(1'b1, FUNC_NONE);  drive_tick(1'b1, FUNC_NONE);
        drive_tick(1'b1, FUNC_NONE);  drive_tick(1'b1, FUNC_SPARE);
        drive_tick(1'b0, FUNC_STOP);  drive_tick(1'b0, FUNC_NONE);
        wait_drained();

        // long trigger pulse written with junk in the upper bits, longest second
        cfg_timing(20'hFFF28, 20'hFFFFF, 20'd3, 20'd0, 20'hFFFFF);
        cfg_close();
        run_random_phase(100);

        // longest measurement period
        cfg_timing(20'd3, 20'd10, 20'd5, 20'hFFFFF, 20'd1);
        cfg_close();
        run_random_phase(40);

        // random small settings under the four idling mixes
        for (p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin src_pct = 0;  snk_pct <= 0;  end
                1: begin src_pct = 76; snk_pct <= 0;  end
                2: begin src_pct = 0;  snk_pct <= 76; end
                default: begin src_pct = 20; snk_pct <= 20; end
            endcase
            cfg_timing(20'($urandom_range(4)), 20'($urandom_range(24)),
                       20'($urandom_range(24)), 20'($urandom_range(12)),
                       20'($urandom_range(6)));
            cfg_write(CFG_START_HOUR, 20'($urandom));
            cfg_write(CFG_START_MINUTE, 20'($urandom));
            cfg_write(CFG_START_SECOND, 20'($urandom));
            cfg_close();
            run_random_phase(25);
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("ultrasonic_echo_ranger test passed");
        end else begin
            $display("ultrasonic_echo_ranger test failed");
        end
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial begin
        #5_000_000;
        $display("ultrasonic_echo_ranger test failed");
        $finish;
    end

endmodule
